### rtl/lhc_pkg.sv
// ----------------------------------------------------------------------------
// lhc_pkg
// Types and constants shared by the link header classifier files.
// ----------------------------------------------------------------------------
`default_nettype none

package lhc_pkg;

    typedef logic [16:0] t_pos;

    typedef enum logic [1:0] {
        LINK_ETH      = 2'd0,
        LINK_RADIOTAP = 2'd1,
        LINK_WIFI     = 2'd2,
        LINK_NONE     = 2'd3
    } t_link;

    // VD_ACCEPT doubles as "no rejection yet" in the early verdict register
    typedef enum logic [2:0] {
        VD_ACCEPT    = 3'd0,
        VD_BAD_HDR   = 3'd1,
        VD_ENCRYPTED = 3'd2,
        VD_NOT_SNAP  = 3'd3,
        VD_BAD_ETYPE = 3'd4,
        VD_BAD_LINK  = 3'd5,
        VD_TRUNCATED = 3'd6
    } t_verdict;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_byte;

    localparam t_pos        POS_MAX      = 17'h1FFFF;
    localparam logic [7:0]  SNAP_MARK    = 8'hAA;
    localparam logic [15:0] ET_IPV4      = 16'h0800;
    localparam logic [15:0] ET_IPV6      = 16'h86DD;
    localparam logic [15:0] ET_ARP       = 16'h0806;
    localparam logic [15:0] ET_PAE       = 16'h888E;
    localparam logic [7:0]  PROTO_IPV4   = 8'd0;
    localparam logic [7:0]  PROTO_IPV6   = 8'd41;

    localparam t_pos        ETH_TYPE_HI  = 17'd12;
    localparam t_pos        ETH_TYPE_LO  = 17'd13;
    localparam t_pos        ETH_HDR_LEN  = 17'd14;
    localparam t_pos        RT_LEN_LO    = 17'd2;
    localparam t_pos        RT_LEN_HI    = 17'd3;
    localparam t_pos        WIFI_START   = 17'd4;
    localparam logic [15:0] RT_MIN_LEN   = 16'd8;
    localparam t_pos        WIFI_HDR_LEN = 17'd24;
    localparam t_pos        QOS_EXTRA    = 17'd2;
    localparam t_pos        ADDR4_EXTRA  = 17'd6;
    localparam t_pos        SNAP_LEN     = 17'd8;

    localparam logic [1:0]  FC_TYPE_DATA = 2'd2;
    localparam logic [3:0]  SUB_PLAIN    = 4'd0;
    localparam logic [3:0]  SUB_QOS      = 4'd8;

endpackage

`default_nettype wire

### rtl/lhc_ifs.sv
// ----------------------------------------------------------------------------
// lhc_ifs
// Valid/ready channels of the link header classifier: byte input,
// result output and link type configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface lhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface lhc_out_if;
    import lhc_pkg::*;
    logic        valid;
    logic        ready;
    t_verdict    verdict;
    logic [7:0]  next_protocol;
    logic [16:0] payload_offset;
    logic [15:0] eth_type;

    modport source (output valid, verdict, next_protocol, payload_offset, eth_type,
                    input ready);
    modport sink   (input valid, verdict, next_protocol, payload_offset, eth_type,
                    output ready);
endinterface

interface lhc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] link_type;

    modport source (output valid, link_type, input ready);
    modport sink   (input valid, link_type, output ready);
endinterface

`default_nettype wire

### rtl/link_header_classifier.sv
// ----------------------------------------------------------------------------
// link_header_classifier
// Streaming link-layer header classifier for Ethernet, radiotap + 802.11
// and raw 802.11 captures, one frame byte per transaction.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained while the result side keeps up.
// Result path: an accepted last byte passes through the input register, then
//   the classification logic into the result register.
// Reset: synchronous, active low; clears the frame state, both valid flags and
//   sets link_type to Ethernet. No clearing pass; ready once reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module link_header_classifier (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lhc_in_if.sink    i_in,
    lhc_cfg_if.sink   i_cfg,
    lhc_out_if.source o_out
);
    import lhc_pkg::*;

    // Link type register. The user must write it only while no byte is in
    // flight; the block does not enforce this. A change mid-frame applies
    // to the bytes that follow. The config channel only stalls during reset.
    t_link r_link_type;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_type <= LINK_ETH;
        end else if (i_cfg.valid) begin
            r_link_type <= t_link'(i_cfg.link_type);
        end
    end

    // Byte in flight between the input register and the classifier.
    logic  s1_valid;
    t_byte s1_byte;
    logic  s1_take;

    // Input register: accepts a new byte when empty or when the held one drains.
    lhc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (s1_take),
        .o_valid (s1_valid),
        .o_byte  (s1_byte)
    );

    // Classifier: updates the per-frame header state on every byte. Only a
    // last byte needs the result register, so mid-frame bytes drain even
    // while an earlier verdict still waits on the output.
    lhc_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (r_link_type),
        .i_valid (s1_valid),
        .i_byte  (s1_byte),
        .o_take  (s1_take),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

### rtl/lhc_in_reg.sv
// ----------------------------------------------------------------------------
// lhc_in_reg
// Input register for the byte stream; refills in the cycle it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module lhc_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    lhc_in_if.sink             i_in,
    input  wire logic          i_take,
    output      logic          o_valid,
    output      lhc_pkg::t_byte o_byte
);
    import lhc_pkg::*;

    logic  r_valid;
    t_byte r_byte;

    // no transaction is taken while reset is held
    assign i_in.ready = i_rst_n && (!r_valid || i_take);
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte.frame_byte <= i_in.frame_byte;
            r_byte.last_byte  <= i_in.last_byte;
        end
    end

endmodule

`default_nettype wire

### rtl/lhc_classify.sv
// ----------------------------------------------------------------------------
// lhc_classify
// Per-frame state, one byte per cycle as results drain; registered verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module lhc_classify (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lhc_pkg::t_link i_link,
    input  wire logic           i_valid,
    input  wire lhc_pkg::t_byte i_byte,
    output      logic           o_take,
    lhc_out_if.source           o_out
);
    import lhc_pkg::*;

    // frame state
    t_pos        r_pos,   n_pos;
    logic [15:0] r_rt,    n_rt;
    logic [15:0] r_fc,    n_fc;
    t_pos        r_hlen,  n_hlen;
    logic [15:0] r_tacc,  n_tacc;
    t_verdict    r_early, n_early;

    // result register
    logic        r_out_valid;
    t_verdict    r_verdict,  n_verdict;
    logic [7:0]  r_proto,    n_proto;
    t_pos        r_offset,   n_offset;
    logic [15:0] r_etype,    n_etype;

    logic        take;
    logic        done;
    logic [7:0]  b;
    t_pos        count;
    t_pos        base;
    logic        wifi_en;
    logic        ev_open;
    logic [15:0] rt_full;
    logic [15:0] fc_full;
    logic [3:0]  sub;
    t_pos        hdr_add;
    t_pos        snap0, snap1, etype_hi, etype_lo;

    assign b      = i_byte.frame_byte;
    assign take   = i_valid && (!i_byte.last_byte || !r_out_valid || o_out.ready);
    assign done   = take && i_byte.last_byte;
    assign o_take = take;

    assign count   = (r_pos == POS_MAX) ? POS_MAX : r_pos + 17'd1;
    assign ev_open = (r_early == VD_ACCEPT);
    assign base    = (i_link == LINK_RADIOTAP) ? {1'b0, r_rt} : '0;
    assign wifi_en = (i_link == LINK_WIFI) ||
                     ((i_link == LINK_RADIOTAP) && (r_pos >= WIFI_START));
    assign rt_full = r_rt | {b, 8'h00};
    assign fc_full = r_fc | {b, 8'h00};
    assign sub     = fc_full[7:4];
    assign hdr_add = WIFI_HDR_LEN + SNAP_LEN
                   + ((sub == SUB_QOS) ? QOS_EXTRA : '0)
                   + ((fc_full[9:8] == 2'b11) ? ADDR4_EXTRA : '0);
    assign snap0    = r_hlen - SNAP_LEN;
    assign snap1    = r_hlen - 17'd7;
    assign etype_hi = r_hlen - 17'd2;
    assign etype_lo = r_hlen - 17'd1;

    // next frame state
    always_comb begin
        n_pos   = count;
        n_rt    = r_rt;
        n_fc    = r_fc;
        n_hlen  = r_hlen;
        n_tacc  = r_tacc;
        n_early = r_early;

        case (i_link)
            LINK_ETH: begin
                if (r_pos == ETH_TYPE_HI) begin
                    n_tacc = {b, 8'h00};
                end else if (r_pos == ETH_TYPE_LO) begin
                    n_tacc = r_tacc | {8'h00, b};
                end
            end
            LINK_RADIOTAP: begin
                if (r_pos == RT_LEN_LO) begin
                    n_rt = {8'h00, b};
                end else if (r_pos == RT_LEN_HI) begin
                    n_rt = rt_full;
                    if (rt_full < RT_MIN_LEN && ev_open) begin
                        n_early = VD_BAD_LINK;
                    end
                end
            end
            default: ;
        endcase

        if (wifi_en && ev_open && r_pos >= base) begin
            if (r_pos == base) begin
                n_fc = {8'h00, b};
            end else if (r_pos == base + 17'd1) begin
                n_fc = fc_full;
                if (fc_full[1:0] != 2'b00 || fc_full[3:2] != FC_TYPE_DATA ||
                    (sub != SUB_PLAIN && sub != SUB_QOS)) begin
                    n_early = VD_BAD_HDR;
                end else if (fc_full[14]) begin
                    n_early = VD_ENCRYPTED;
                end else begin
                    n_hlen = base + hdr_add;
                end
            end else if (r_hlen != '0) begin
                if ((r_pos == snap0 || r_pos == snap1) && b != SNAP_MARK) begin
                    n_early = VD_NOT_SNAP;
                end else if (r_pos == etype_hi) begin
                    n_tacc = {b, 8'h00};
                end else if (r_pos == etype_lo) begin
                    n_tacc = r_tacc | {8'h00, b};
                end
            end
        end
    end

    // verdict from the state as it stands after this byte
    always_comb begin
        n_verdict = VD_ACCEPT;
        n_proto   = PROTO_IPV4;
        n_offset  = '0;
        n_etype   = '0;
        if (i_link == LINK_NONE) begin
            n_verdict = VD_BAD_LINK;
        end else if (i_link == LINK_ETH && count < ETH_HDR_LEN) begin
            n_verdict = VD_TRUNCATED;
        end else if (i_link != LINK_ETH && n_early != VD_ACCEPT) begin
            n_verdict = n_early;
        end else if (i_link != LINK_ETH && (n_hlen == '0 || count < n_hlen)) begin
            n_verdict = VD_TRUNCATED;
        end else begin
            n_offset = (i_link == LINK_ETH) ? ETH_HDR_LEN : n_hlen;
            n_etype  = n_tacc;
            case (n_tacc)
                ET_IPV4:        n_proto   = PROTO_IPV4;
                ET_IPV6:        n_proto   = PROTO_IPV6;
                ET_ARP, ET_PAE: n_verdict = VD_BAD_ETYPE;
                default:        n_verdict = VD_BAD_ETYPE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_rt    <= '0;
            r_fc    <= '0;
            r_hlen  <= '0;
            r_tacc  <= '0;
            r_early <= VD_ACCEPT;
        end else if (done) begin
            r_pos   <= '0;
            r_rt    <= '0;
            r_fc    <= '0;
            r_hlen  <= '0;
            r_tacc  <= '0;
            r_early <= VD_ACCEPT;
        end else if (take) begin
            r_pos   <= n_pos;
            r_rt    <= n_rt;
            r_fc    <= n_fc;
            r_hlen  <= n_hlen;
            r_tacc  <= n_tacc;
            r_early <= n_early;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_verdict <= n_verdict;
            r_proto   <= n_proto;
            r_offset  <= n_offset;
            r_etype   <= n_etype;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.verdict        = r_verdict;
    assign o_out.next_protocol  = r_proto;
    assign o_out.payload_offset = r_offset;
    assign o_out.eth_type       = r_etype;

endmodule

`default_nettype wire
